// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ===== design/btpc_pkg.sv =====
// ---------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the baro temperature/pressure compensation.
// ---------------------------------------------------------------------------
package btpc_pkg;

  localparam int RawW   = 20;
  localparam int TempW  = 15;
  localparam int PressW = 25;
  localparam int CfgW   = 48;
  localparam int CfgIdxW = 2;
  localparam int QW     = 36;   // quotient bits resolved by the divider

  localparam logic signed [TempW-1:0] TempMin = -15'sd4000;
  localparam logic signed [TempW-1:0] TempMax = 15'sd8500;
  localparam logic [PressW-1:0]       PressMax = 25'd28160000;
  localparam logic signed [52:0]      NLim = 53'sh0A_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTemp   = 2'd0,
    CfgPressA = 2'd1,
    CfgPressB = 2'd2,
    CfgPressC = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  // temperature result that rides along with the pressure work
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic                    sat;
  } side_t;

  typedef struct packed {
    logic signed [24:0] a0;
    logic [RawW-1:0]    raw_p;
    side_t              side;
  } tmp_t;

  typedef struct packed {
    logic signed [63:0] num;
    logic signed [37:0] dvs;
    logic               inv;
    side_t              side;
  } pol_t;

  typedef struct packed {
    logic signed [36:0] p;
    logic               inv;
    side_t              side;
  } quo_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PressW-1:0]       press;
    logic                    inv;
    logic                    sat;
  } res_t;

endpackage

// ===== design/btpc_temp.sv =====
// ---------------------------------------------------------------------------
// btpc_temp
// Five-stage temperature polynomial: fine temperature, centi-degC output.
// ---------------------------------------------------------------------------
module btpc_temp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [btpc_pkg::RawW-1:0]  raw_t_i,
  input  logic [btpc_pkg::RawW-1:0]  raw_p_i,
  input  btpc_pkg::calib_t           calib_i,
  output logic                       valid_o,
  output btpc_pkg::tmp_t             out_o
);
  import btpc_pkg::*;

  logic [4:0] vld_q;

  logic signed [15:0] t2_s, t3_s;
  assign t2_s = calib_i.t2;
  assign t3_s = calib_i.t3;

  // stage 1
  logic signed [17:0] dt1_d, dt1_q;
  logic signed [16:0] dd;
  logic [15:0]        dab_d, dab_q;
  logic [RawW-1:0]    rp1_q, rp2_q, rp3_q, rp4_q;

  always_comb begin
    dt1_d = $signed({1'b0, raw_t_i[19:3]}) - $signed({1'b0, calib_i.t1, 1'b0});
    dd    = $signed({1'b0, raw_t_i[19:4]}) - $signed({1'b0, calib_i.t1});
    dab_d = dd[16] ? 16'(-dd) : 16'(dd);
  end

  // stage 2
  logic signed [33:0] m1_d, m1_q;
  logic [31:0]        sq_d, sq_q;
  assign m1_d = 34'(dt1_q) * 34'(t2_s);
  assign sq_d = 32'(dab_q) * 32'(dab_q);

  // stage 3
  logic signed [22:0] v1_d, v1_q;
  logic signed [36:0] m2_d, m2_q;
  assign v1_d = 23'(m1_q >>> 11);
  assign m2_d = 37'($signed({1'b0, sq_q[31:12]})) * 37'(t3_s);

  // stage 4
  logic signed [23:0] tf_d, tf_q;
  assign tf_d = 24'(v1_q) + 24'(m2_q >>> 14);

  // stage 5
  logic signed [26:0] t5;
  logic signed [18:0] tsh;
  tmp_t               out_d, out_q;

  always_comb begin
    t5 = 27'(tf_q) * 27'sd5 + 27'sd128;
    tsh = 19'(t5 >>> 8);
    out_d.a0    = 25'(tf_q) - 25'sd128000;
    out_d.raw_p = rp4_q;
    if (tsh < 19'(TempMin)) begin
      out_d.side.temp = TempMin;
      out_d.side.sat  = 1'b1;
    end else if (tsh > 19'(TempMax)) begin
      out_d.side.temp = TempMax;
      out_d.side.sat  = 1'b1;
    end else begin
      out_d.side.temp = 15'(tsh);
      out_d.side.sat  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dt1_q <= dt1_d;
      dab_q <= dab_d;
      rp1_q <= raw_p_i;
      m1_q  <= m1_d;
      sq_q  <= sq_d;
      rp2_q <= rp1_q;
      v1_q  <= v1_d;
      m2_q  <= m2_d;
      rp3_q <= rp2_q;
      tf_q  <= tf_d;
      rp4_q <= rp3_q;
      out_q <= out_d;
    end
  end

  assign valid_o = vld_q[4];
  assign out_o   = out_q;

endmodule

// ===== design/btpc_poly.sv =====
// ---------------------------------------------------------------------------
// btpc_poly
// Seven-stage pressure polynomial: numerator, scale divisor and zero check.
// ---------------------------------------------------------------------------
module btpc_poly (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  btpc_pkg::tmp_t   in_i,
  input  btpc_pkg::calib_t calib_i,
  output logic             valid_o,
  output btpc_pkg::pol_t   out_o
);
  import btpc_pkg::*;

  localparam logic signed [53:0] XOfs = 54'sd1 <<< 47;

  logic [6:0] vld_q;

  logic signed [15:0] p2_s, p3_s, p4_s, p5_s, p6_s;
  assign p2_s = calib_i.p2;
  assign p3_s = calib_i.p3;
  assign p4_s = calib_i.p4;
  assign p5_s = calib_i.p5;
  assign p6_s = calib_i.p6;

  // stage 1: a*a, a*P5, a*P2
  logic signed [49:0] aa_full;
  logic [44:0]        aa_q;
  logic signed [39:0] ap5_d, ap2_d, ap5_q, ap2_q, ap5_2q, ap2_2q, ap5_3q, ap2_3q;
  logic [RawW-1:0]    rp1_q, rp2_q, rp3_q, rp4_q;
  side_t              sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q;

  assign aa_full = 50'(in_i.a0) * 50'(in_i.a0);
  assign ap5_d   = 40'(in_i.a0) * 40'(p5_s);
  assign ap2_d   = 40'(in_i.a0) * 40'(p2_s);

  // stage 2: a*a times P6 and P3, split into two halves
  logic signed [37:0] h6_d, h3_d, h6_q, h3_q;
  logic signed [38:0] l6_d, l3_d, l6_q, l3_q;
  assign h6_d = 38'($signed({1'b0, aa_q[44:23]})) * 38'(p6_s);
  assign h3_d = 38'($signed({1'b0, aa_q[44:23]})) * 38'(p3_s);
  assign l6_d = 39'($signed({1'b0, aa_q[22:0]})) * 39'(p6_s);
  assign l3_d = 39'($signed({1'b0, aa_q[22:0]})) * 39'(p3_s);

  // stage 3: recombine halves
  logic signed [60:0] aap6_d, aap3_d, aap6_q, aap3_q;
  assign aap6_d = (61'(h6_q) <<< 23) + 61'(l6_q);
  assign aap3_d = (61'(h3_q) <<< 23) + 61'(l3_q);

  // stage 4: b and the offset term ahead of the P1 scaling
  logic signed [63:0] b_d, b_q;
  logic signed [53:0] x_d, x_q;
  assign b_d = 64'(aap6_q) + (64'(ap5_3q) <<< 17) + (64'(p4_s) <<< 35);
  assign x_d = 54'(aap3_q >>> 8) + (54'(ap2_3q) <<< 12) + XOfs;

  // stage 5: raw numerator, x*P1 as two partial products
  logic [20:0]        dp;
  logic signed [65:0] nraw_d, nraw_q;
  logic signed [43:0] ph_d, pl_d, ph_q, pl_q;
  logic signed [16:0] p1_s;
  always_comb begin
    dp     = 21'h100000 - 21'(rp4_q);
    nraw_d = 66'($signed({1'b0, dp, 31'b0})) - 66'(b_q);
    p1_s   = $signed({1'b0, calib_i.p1});
    ph_d   = 44'($signed(x_q[53:27])) * 44'(p1_s);
    pl_d   = 44'($signed({1'b0, x_q[26:0]})) * 44'(p1_s);
  end

  // stage 6: divisor = floor(x*P1 / 2^33), numerator clamp
  logic signed [70:0] full;
  logic signed [37:0] dvs_d, dvs_q;
  logic signed [52:0] n_d, n_q;
  always_comb begin
    full  = (71'(ph_q) <<< 27) + 71'(pl_q);
    dvs_d = 38'(full >>> 33);
    if (nraw_q > 66'(NLim)) begin
      n_d = NLim;
    end else if (nraw_q < -66'(NLim)) begin
      n_d = -NLim;
    end else begin
      n_d = 53'(nraw_q);
    end
  end

  // stage 7
  pol_t out_d, out_q;
  always_comb begin
    out_d.num  = 64'(n_q) * 64'sd3125;
    out_d.dvs  = dvs_q;
    out_d.inv  = (dvs_q == '0);
    out_d.side = sd6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa_q   <= aa_full[44:0];
      ap5_q  <= ap5_d;
      ap2_q  <= ap2_d;
      rp1_q  <= in_i.raw_p;
      sd1_q  <= in_i.side;
      h6_q   <= h6_d;
      h3_q   <= h3_d;
      l6_q   <= l6_d;
      l3_q   <= l3_d;
      ap5_2q <= ap5_q;
      ap2_2q <= ap2_q;
      rp2_q  <= rp1_q;
      sd2_q  <= sd1_q;
      aap6_q <= aap6_d;
      aap3_q <= aap3_d;
      ap5_3q <= ap5_2q;
      ap2_3q <= ap2_2q;
      rp3_q  <= rp2_q;
      sd3_q  <= sd2_q;
      b_q    <= b_d;
      x_q    <= x_d;
      rp4_q  <= rp3_q;
      sd4_q  <= sd3_q;
      nraw_q <= nraw_d;
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      sd5_q  <= sd4_q;
      n_q    <= n_d;
      dvs_q  <= dvs_d;
      sd6_q  <= sd5_q;
      out_q  <= out_d;
    end
  end

  assign valid_o = vld_q[6];
  assign out_o   = out_q;

endmodule

// ===== design/btpc_div.sv =====
// ---------------------------------------------------------------------------
// btpc_div
// Pipelined signed divider, one quotient bit per stage, truncating, with
// the quotient clamped to +-2^35.
// ---------------------------------------------------------------------------
module btpc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  btpc_pkg::pol_t in_i,
  output logic           valid_o,
  output btpc_pkg::quo_t out_o
);
  import btpc_pkg::*;

  typedef struct packed {
    logic [37:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [36:0] dvs;
    logic        neg;
    logic        ovf;
    logic        inv;
    side_t       side;
  } div_st_t;

  // stage A: magnitudes and quotient sign
  logic        va_q, vb_q;
  logic [62:0] anum_d, anum_q;
  logic [36:0] advs_d, advs_q;
  logic        neg_q, inv_q;
  side_t       sd_q;

  always_comb begin
    anum_d = in_i.num[63] ? 63'(-in_i.num) : in_i.num[62:0];
    advs_d = in_i.dvs[37] ? 37'(-in_i.dvs) : in_i.dvs[36:0];
  end

  // stage B: overflow check and initial partial remainder
  div_st_t st_d;
  div_st_t st_q [QW+1];
  logic [QW:0] vld_q;

  always_comb begin
    st_d.rem  = 38'(anum_q[62:QW]);
    st_d.low  = anum_q[QW-1:0];
    st_d.quo  = '0;
    st_d.dvs  = advs_q;
    st_d.neg  = neg_q;
    st_d.ovf  = (37'(anum_q[62:QW]) >= advs_q);   // quotient needs more than QW bits
    st_d.inv  = inv_q;
    st_d.side = sd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      va_q     <= valid_i;
      vld_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      anum_q <= anum_d;
      advs_q <= advs_d;
      neg_q  <= in_i.num[63] ^ in_i.dvs[37];
      inv_q  <= in_i.inv;
      sd_q   <= in_i.side;
      st_q[0] <= st_d;
    end
  end

  // restoring steps
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [37:0] sh;
    logic        ge;
    div_st_t     nx;

    always_comb begin
      sh = {st_q[k].rem[36:0], st_q[k].low[QW-1]};
      ge = (sh >= {1'b0, st_q[k].dvs});
      nx = st_q[k];
      nx.rem = ge ? sh - {1'b0, st_q[k].dvs} : sh;
      nx.low = {st_q[k].low[QW-2:0], 1'b0};
      nx.quo = {st_q[k].quo[QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nx;
      end
    end
  end

  // final stage: clamp and sign
  logic [36:0] mag;
  quo_t        out_d, out_q;

  always_comb begin
    if (st_q[QW].ovf || (st_q[QW].quo[QW-1] && |st_q[QW].quo[QW-2:0])) begin
      mag = 37'd1 << (QW - 1);
    end else begin
      mag = 37'(st_q[QW].quo);
    end
    out_d.p    = st_q[QW].neg ? -$signed(mag) : $signed(mag);
    out_d.inv  = st_q[QW].inv;
    out_d.side = st_q[QW].side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vb_q;
  assign out_o   = out_q;

endmodule

// ===== design/btpc_post.sv =====
// ---------------------------------------------------------------------------
// btpc_post
// Four-stage pressure correction terms, P7 offset and output saturation.
// ---------------------------------------------------------------------------
module btpc_post (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  btpc_pkg::quo_t   in_i,
  input  btpc_pkg::calib_t calib_i,
  output logic             valid_o,
  output btpc_pkg::res_t   out_o
);
  import btpc_pkg::*;

  logic [3:0] vld_q;

  logic signed [15:0] p7_s, p8_s, p9_s;
  assign p7_s = calib_i.p7;
  assign p8_s = calib_i.p8;
  assign p9_s = calib_i.p9;

  // stage 1: (p>>13)^2 and P8*p
  logic signed [23:0] q13;
  logic signed [47:0] qsq;
  logic [44:0]        qq_q;
  logic signed [52:0] p8p_d, p8p_q, p8p_2q;
  logic signed [36:0] p1_q, p2_q;
  logic               inv1_q, inv2_q, inv3_q;
  side_t              sd1_q, sd2_q, sd3_q;

  always_comb begin
    q13   = 24'(in_i.p >>> 13);
    qsq   = 48'(q13) * 48'(q13);
    p8p_d = 53'(in_i.p) * 53'(p8_s);
  end

  // stage 2
  logic signed [61:0] c1m_d, c1m_q;
  assign c1m_d = 62'($signed({1'b0, qq_q})) * 62'(p9_s);

  // stage 3
  logic signed [39:0] s_d, s_q;
  assign s_d = 40'(p2_q) + 40'(c1m_q >>> 25) + 40'(p8p_2q >>> 19);

  // stage 4
  logic signed [39:0] r;
  res_t               out_d, out_q;
  logic               psat;

  always_comb begin
    r = 40'(s_q >>> 8) + (40'(p7_s) <<< 4);
    psat = 1'b0;
    if (inv3_q) begin
      out_d.press = '0;
    end else if (r < 0) begin
      out_d.press = '0;
      psat = 1'b1;
    end else if (r > 40'(PressMax)) begin
      out_d.press = PressMax;
      psat = 1'b1;
    end else begin
      out_d.press = 25'(r);
    end
    out_d.temp = sd3_q.temp;
    out_d.inv  = inv3_q;
    out_d.sat  = sd3_q.sat | psat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qq_q   <= qsq[44:0];
      p8p_q  <= p8p_d;
      p1_q   <= in_i.p;
      inv1_q <= in_i.inv;
      sd1_q  <= in_i.side;
      c1m_q  <= c1m_d;
      p8p_2q <= p8p_q;
      p2_q   <= p1_q;
      inv2_q <= inv1_q;
      sd2_q  <= sd1_q;
      s_q    <= s_d;
      inv3_q <= inv2_q;
      sd3_q  <= sd2_q;
      out_q  <= out_d;
    end
  end

  assign valid_o = vld_q[3];
  assign out_o   = out_q;

endmodule

// ===== design/baro_temp_pressure_compensation.sv =====
// ---------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Streaming temperature and pressure compensation for 20-bit raw readings.
// ---------------------------------------------------------------------------
// Takes one request (raw temperature, raw pressure) per clock while the skid
// slot is free and returns temperature in 0.01 degC and pressure in 1/256 Pa.
// Fully pipelined: a request passes 5 temperature stages, 7 polynomial stages,
// 39 divider stages (its restoring steps resolving one quotient bit each),
// 4 correction stages and the output register to reach the master side. tuser
// flags a zero pressure divisor (pressure forced to 0) and any clipping of
// either output. Calibration words must be written through the cfg port only
// while the stream is idle; the block itself does not enforce this.
module baro_temp_pressure_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [btpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [btpc_pkg::CfgW-1:0]     cfg_data_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,   // raw_temperature, raw_pressure
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,   // temperature_centi, pressure_q8
  output logic [1:0]                    m_axis_tuser    // pressure_invalid, saturated
);
  import btpc_pkg::*;
  `include "assert_macros.svh"

  logic [CfgW-1:0] tcal_q, pa_q, pb_q, pc_q;
  calib_t          calib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTemp:   tcal_q <= cfg_data_i;
        CfgPressA: pa_q   <= cfg_data_i;
        CfgPressB: pb_q   <= cfg_data_i;
        CfgPressC: pc_q   <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    calib.t1 = tcal_q[15:0];
    calib.t2 = tcal_q[31:16];
    calib.t3 = tcal_q[47:32];
    calib.p1 = pa_q[15:0];
    calib.p2 = pa_q[31:16];
    calib.p3 = pa_q[47:32];
    calib.p4 = pb_q[15:0];
    calib.p5 = pb_q[31:16];
    calib.p6 = pb_q[47:32];
    calib.p7 = pc_q[15:0];
    calib.p8 = pc_q[31:16];
    calib.p9 = pc_q[47:32];
  end

  // whole pipeline moves while the skid slot is free
  logic out_valid_q, skid_valid_q, en;
  res_t out_q, skid_q;
  assign en = !skid_valid_q;
  assign s_axis_tready = en;

  logic tmp_v, pol_v, quo_v, res_v;
  tmp_t tmp;
  pol_t pol;
  quo_t quo;
  res_t res;

  btpc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .raw_t_i (s_axis_tdata[19:0]),
    .raw_p_i (s_axis_tdata[39:20]),
    .calib_i (calib),
    .valid_o (tmp_v),
    .out_o   (tmp)
  );

  btpc_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tmp_v),
    .in_i    (tmp),
    .calib_i (calib),
    .valid_o (pol_v),
    .out_o   (pol)
  );

  btpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pol_v),
    .in_i    (pol),
    .valid_o (quo_v),
    .out_o   (quo)
  );

  btpc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quo_v),
    .in_i    (quo),
    .calib_i (calib),
    .valid_o (res_v),
    .out_o   (res)
  );

  logic leave;
  assign leave = res_v && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= leave;
      end
    end else if (leave) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (leave) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.press, out_q.temp};
  assign m_axis_tuser  = {out_q.sat, out_q.inv};

  `ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni, skid_valid_q && !out_valid_q)
  `ASSERT_AT(a_inv_press_zero, clk_i, rst_ni, out_valid_q && out_q.inv |-> out_q.press == '0)
  `ASSERT_AT(a_press_range, clk_i, rst_ni, out_valid_q |-> out_q.press <= PressMax)
  `ASSERT_AT(a_temp_range, clk_i, rst_ni, out_valid_q |-> out_q.temp >= TempMin && out_q.temp <= TempMax)

endmodule

// ===== test/btpc_checker.sv =====
// ---------------------------------------------------------------------------
// btpc_checker
// Watches the config port and both streams of the compensation block,
// predicts each result from the raw readings and compares field by field.
// ---------------------------------------------------------------------------
module btpc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [btpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [btpc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,   // raw_temperature, raw_pressure
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [39:0]                  m_axis_tdata,   // temperature_centi, pressure_q8
  input  logic [1:0]                   m_axis_tuser,   // pressure_invalid, saturated
  output int                           fail_count_o,
  output int                           pending_o
);
  import btpc_pkg::*;

  localparam longint NumLim  = 64'sd2814749767106560;
  localparam longint QuoLim  = 64'sd34359738368;

  logic [CfgW-1:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  res_t            expected_res_q[$];

  function automatic longint ufld(logic [CfgW-1:0] r, int pos);
    return longint'({48'b0, r[pos +: 16]});
  endfunction

  function automatic longint sfld(logic [CfgW-1:0] r, int pos);
    logic signed [15:0] f;
    f = r[pos +: 16];
    return longint'(f);
  endfunction

  function automatic res_t compensate(logic [RawW-1:0] raw_t, logic [RawW-1:0] raw_p);
    longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, v2, d, tfine, temp, a, b, x, hi, lo, n, p, q, c1, c2;
    res_t   r;
    adc_t = longint'({44'b0, raw_t});
    adc_p = longint'({44'b0, raw_p});
    t1 = ufld(temp_cal, 0);     t2 = sfld(temp_cal, 16);    t3 = sfld(temp_cal, 32);
    p1 = ufld(press_cal_a, 0);  p2 = sfld(press_cal_a, 16); p3 = sfld(press_cal_a, 32);
    p4 = sfld(press_cal_b, 0);  p5 = sfld(press_cal_b, 16); p6 = sfld(press_cal_b, 32);
    p7 = sfld(press_cal_c, 0);  p8 = sfld(press_cal_c, 16); p9 = sfld(press_cal_c, 32);
    r = '0;

    v1 = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tfine = v1 + v2;

    temp = (tfine * 5 + 128) >>> 8;
    if (temp < -4000) begin
      temp = -4000;
      r.sat = 1'b1;
    end
    if (temp > 8500) begin
      temp = 8500;
      r.sat = 1'b1;
    end
    r.temp = temp[TempW-1:0];

    a = tfine - 128000;
    b = a * a * p6 + a * p5 * 131072 + p4 * (longint'(1) << 35);
    a = ((a * a * p3) >>> 8) + a * p2 * 4096;
    // floor(x * P1 / 2^33) split so that no product overflows
    x = (longint'(1) << 47) + a;
    hi = x >>> 17;
    lo = x - hi * 131072;
    a = (hi * p1 + ((lo * p1) >>> 17)) >>> 16;

    if (a == 0) begin
      r.inv = 1'b1;
    end else begin
      n = (1048576 - adc_p) * (longint'(1) << 31) - b;
      if (n > NumLim) n = NumLim;
      if (n < -NumLim) n = -NumLim;
      p = (n * 3125) / a;
      if (p > QuoLim) p = QuoLim;
      if (p < -QuoLim) p = -QuoLim;
      q = p >>> 13;
      c1 = (p9 * q * q) >>> 25;
      c2 = (p8 * p) >>> 19;
      p = ((p + c1 + c2) >>> 8) + p7 * 16;
      if (p < 0) begin
        p = 0;
        r.sat = 1'b1;
      end
      if (p > 28160000) begin
        p = 28160000;
        r.sat = 1'b1;
      end
      r.press = p[PressW-1:0];
    end
    return r;
  endfunction

  assign pending_o = expected_res_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    res_t got;
    if (!rst_ni) begin
      temp_cal <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
      fail_count_o <= 0;
      expected_res_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgTemp:   temp_cal <= cfg_data_i;
          CfgPressA: press_cal_a <= cfg_data_i;
          CfgPressB: press_cal_b <= cfg_data_i;
          CfgPressC: press_cal_c <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_res_q.push_back(compensate(s_axis_tdata[19:0], s_axis_tdata[39:20]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.temp  = m_axis_tdata[14:0];
        got.press = m_axis_tdata[39:15];
        got.inv   = m_axis_tuser[0];
        got.sat   = m_axis_tuser[1];
        if (expected_res_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_res_q.pop_front();
          if (got.temp !== exp_r.temp)
            $error("temperature_centi: expected %0d, got %0d", exp_r.temp, got.temp);
          if (got.press !== exp_r.press)
            $error("pressure_q8: expected %0d, got %0d", exp_r.press, got.press);
          if (got.inv !== exp_r.inv)
            $error("pressure_invalid: expected %0d, got %0d", exp_r.inv, got.inv);
          if (got.sat !== exp_r.sat)
            $error("saturated: expected %0d, got %0d", exp_r.sat, got.sat);
          if (got !== exp_r)
            fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

// ===== test/tb_baro_temp_pressure_compensation.sv =====
// ---------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation
// Stimulus and verdict for the compensation block: several calibration sets,
// directed corner readings, then random readings under varying back-pressure.
// ---------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation;
  import btpc_pkg::*;

  localparam int StallLimit = 4000;
  localparam int Drain      = 70;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               s_axis_tvalid, s_axis_tready;
  logic [39:0]        s_axis_tdata;
  logic               m_axis_tvalid, m_axis_tready;
  logic [39:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  int                 fail_count, pending;
  int                 tx_idle_pct, rx_idle_pct, hold_cnt, stall_cnt;
  logic               hold_req;

  baro_temp_pressure_compensation dut (.*);

  btpc_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic load_calib(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgTemp;   cfg_data_i <= tc; @(posedge clk_i);
    cfg_idx_i <= CfgPressA; cfg_data_i <= pa; @(posedge clk_i);
    cfg_idx_i <= CfgPressB; cfg_data_i <= pb; @(posedge clk_i);
    cfg_idx_i <= CfgPressC; cfg_data_i <= pc; @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic [19:0] raw_t, logic [19:0] raw_p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw_p, raw_t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70)
        send(20'($urandom_range(600000, 400000)), 20'($urandom_range(450000, 250000)));
      else
        send(20'($urandom), 20'($urandom));
    end
  endtask

  // typical calibration of a real part
  localparam logic [47:0] TypT = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypA = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TypB = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TypC = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgTemp;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    hold_req <= 1'b0;
    hold_cnt = 0;
    tx_idle_pct = 31;
    rx_idle_pct = 88;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: divisor is zero, pressure must be flagged invalid
    send(20'd519888, 20'd415148);
    send(20'hFFFFF, 20'h00000);
    send(20'h00000, 20'hFFFFF);
    drain_all();

    load_calib(TypT, TypA, TypB, TypC);
    send(20'd519888, 20'd415148);
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    send(20'd300000, 20'd415148);    // cold clip
    send(20'd700000, 20'd415148);    // hot reading
    send(20'd519888, 20'd100000);    // high pressure clip
    send(20'd519888, 20'd1000000);   // low pressure reading
    send(20'hAAAAA, 20'h55555);
    send(20'h55555, 20'hAAAAA);
    drain_all();

    // extremes: every word all ones, then at its signed maximum, then minimum
    load_calib('1, '1, '1, '1);
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    send(20'd519888, 20'd415148);
    drain_all();
    load_calib({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send(20'd0, 20'hFFFFF);
    send(20'hFFFFF, 20'd0);
    drain_all();
    load_calib({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send(20'd0, 20'd0);
    send(20'hFFFFF, 20'hFFFFF);
    drain_all();

    load_calib(TypT, TypA, TypB, TypC);
    send_random(250);
    drain_all();

    tx_idle_pct = 88;
    rx_idle_pct = 31;
    load_calib(48'($urandom) | (48'($urandom) << 32), TypA, TypB,
               48'($urandom) | (48'($urandom) << 32));
    send_random(100);
    drain_all();
    load_calib(TypT, 48'($urandom) | (48'($urandom) << 32),
               48'($urandom) | (48'($urandom) << 32), TypC);
    send_random(100);
    drain_all();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_calib(TypT, TypA, TypB, TypC);
    hold_req <= 1'b1;
    send_random(150);
    drain_all();
    load_calib('1, '1, '1, '1);
    send_random(150);
    drain_all();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/btpc_pkg.sv
design/btpc_temp.sv
design/btpc_poly.sv
design/btpc_div.sv
design/btpc_post.sv
design/baro_temp_pressure_compensation.sv
test/btpc_checker.sv
test/tb_baro_temp_pressure_compensation.sv
